// ===== rtl/core/mrfb_pkg.sv =====
// Shared constants, state type and control structs for the Modbus RTU frame builder.
package mrfb_pkg;

    localparam logic [15:0] CRC_POLY      = 16'hA001;
    localparam logic [15:0] CRC_INIT      = 16'hFFFF;
    localparam int          PAYLOAD_BYTES = 7;
    localparam int          PAYLOAD_W     = PAYLOAD_BYTES * 8;
    localparam int          LEN_W         = $clog2(PAYLOAD_BYTES + 1);

    localparam logic [LEN_W-1:0] REQ_LEN = LEN_W'(6);
    localparam logic [LEN_W-1:0] RSP_LEN = LEN_W'(7);

    localparam logic CMD_REQUEST  = 1'b0;
    localparam logic CMD_RESPONSE = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_CRUNCH,
        ST_CRC_LO,
        ST_CRC_HI
    } t_state;

    // control from the sequencer to the serial CRC unit
    typedef struct packed {
        logic       init;
        logic       load;
        logic [7:0] byte_in;
    } t_crc_ctl;

    // control from the sequencer to the payload shifter
    typedef struct packed {
        logic load;
        logic shift;
    } t_pay_ctl;

endpackage

// ===== rtl/core/mrfb_payload_shift.sv =====
// Payload byte shifter: holds the frame payload and hands it out one byte at a time.
module mrfb_payload_shift
    import mrfb_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_pay_ctl             i_ctl,
    input  logic [PAYLOAD_W-1:0] i_bytes,
    input  logic [LEN_W-1:0]     i_len,
    output logic [7:0]           o_byte,
    output logic                 o_empty
);

    logic [PAYLOAD_W-1:0] r_bytes;
    logic [PAYLOAD_W-1:0] n_bytes;
    logic [LEN_W-1:0]     r_left;
    logic [LEN_W-1:0]     n_left;

    always_comb begin
        n_bytes = r_bytes;
        n_left  = r_left;
        if (i_ctl.load) begin
            n_bytes = i_bytes;
            n_left  = i_len;
        end else if (i_ctl.shift) begin
            // advance to the next byte, oldest in the low bits
            n_bytes = {8'h00, r_bytes[PAYLOAD_W-1:8]};
            n_left  = r_left - LEN_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        r_bytes <= n_bytes;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
        end else begin
            r_left <= n_left;
        end
    end

    assign o_byte  = r_bytes[7:0];
    assign o_empty = (r_left == '0);

endmodule

// ===== rtl/core/mrfb_crc_serial.sv =====
// Bit-serial Modbus CRC-16: folds one byte into the CRC bit by bit, LSB first.
module mrfb_crc_serial
    import mrfb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_crc_ctl    i_ctl,
    output logic [15:0] o_crc,
    output logic        o_busy
);

    logic [15:0] r_crc;
    logic [15:0] n_crc;
    logic [7:0]  r_bits;
    logic [7:0]  n_bits;
    logic [2:0]  r_cnt;
    logic [2:0]  n_cnt;
    logic        r_run;
    logic        n_run;
    logic        fb;

    always_comb begin
        n_crc  = r_crc;
        n_bits = r_bits;
        n_cnt  = r_cnt;
        n_run  = r_run;
        fb     = r_crc[0] ^ r_bits[0];
        if (i_ctl.init) begin
            n_crc = CRC_INIT;
        end
        if (i_ctl.load) begin
            n_bits = i_ctl.byte_in;
            n_cnt  = '0;
            n_run  = 1'b1;
        end else if (r_run) begin
            n_crc  = {1'b0, r_crc[15:1]} ^ (fb ? CRC_POLY : 16'h0000);
            n_bits = {1'b0, r_bits[7:1]};
            n_cnt  = r_cnt + 3'd1;
            if (r_cnt == 3'd7) begin
                n_run = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_bits <= n_bits;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc <= CRC_INIT;
            r_cnt <= '0;
            r_run <= 1'b0;
        end else begin
            r_crc <= n_crc;
            r_cnt <= n_cnt;
            r_run <= n_run;
        end
    end

    assign o_crc  = r_crc;
    assign o_busy = r_run;

endmodule

// ===== rtl/core/modbus_rtu_frame_builder_top.sv =====
// Modbus RTU frame builder top level: sequencer, output register and checks.
//
// One request item on the slave side becomes a complete Modbus RTU frame on
// the master side, one byte per item, closed by the CRC-16 (reflected poly
// 0xA001, preset 0xFFFF, low byte first); tlast marks the high CRC byte.
// tuser selects the frame: 0 gives a master read request (address, function,
// start address hi/lo, quantity hi/lo, CRC: 8 bytes), 1 gives a slave
// response (address, function, byte count, four data bytes MSB first, CRC:
// 9 bytes). The CRC is computed one bit per clock by a serial unit: each
// payload byte is handed out and loaded into the CRC unit, folded in by
// eight CRC bit steps, and then the sequencer waits to see the CRC unit
// finish; each CRC byte is then handed out from its own state. The sequencer
// returns to idle once the high CRC byte is loaded into the output register.
// A new request is accepted only when the previous frame has been
// handed to the output register. The output register decouples the two
// sides: a payload byte waits there while its CRC bits are folded in, and
// back-pressure on the master side simply stalls the sequencer.
module modbus_rtu_frame_builder_top
    import mrfb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // slave_address[7:0], function_code[15:8], start_address[31:16],
    // quantity[47:32], byte_count[55:48], data_word[87:56]
    input  logic [87:0] s_axis_tdata,
    // command[0]
    input  logic [0:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // frame_byte[7:0]
    output logic [7:0]  m_axis_tdata,
    // last_byte
    output logic        m_axis_tlast
);

    // unpacked request fields
    logic        in_cmd;
    logic [7:0]  in_addr;
    logic [7:0]  in_func;
    logic [15:0] in_start;
    logic [15:0] in_qty;
    logic [7:0]  in_cnt;
    logic [31:0] in_data;

    assign in_cmd   = s_axis_tuser[0];
    assign in_addr  = s_axis_tdata[7:0];
    assign in_func  = s_axis_tdata[15:8];
    assign in_start = s_axis_tdata[31:16];
    assign in_qty   = s_axis_tdata[47:32];
    assign in_cnt   = s_axis_tdata[55:48];
    assign in_data  = s_axis_tdata[87:56];

    // payload in transmission order, first byte lowest
    logic [PAYLOAD_W-1:0] pay_bytes;
    logic [LEN_W-1:0]     pay_len;

    always_comb begin
        if (in_cmd == CMD_RESPONSE) begin
            pay_bytes = {in_data[7:0], in_data[15:8], in_data[23:16], in_data[31:24],
                         in_cnt, in_func, in_addr};
            pay_len   = RSP_LEN;
        end else begin
            pay_bytes = {8'h00, in_qty[7:0], in_qty[15:8], in_start[7:0], in_start[15:8],
                         in_func, in_addr};
            pay_len   = REQ_LEN;
        end
    end

    t_state      r_state;
    t_state      n_state;
    t_pay_ctl    pay_ctl;
    t_crc_ctl    crc_ctl;
    logic [7:0]  pay_byte;
    logic        pay_empty;
    logic [15:0] crc_val;
    logic        crc_busy;

    logic        in_acc;
    logic        out_free;
    logic        out_load;
    logic [7:0]  out_byte;
    logic        out_last;

    logic        r_out_valid;
    logic        n_out_valid;
    logic [7:0]  r_out_byte;
    logic [7:0]  n_out_byte;
    logic        r_out_last;
    logic        n_out_last;

    assign in_acc   = s_axis_tvalid && s_axis_tready;
    // output slot free when empty or being drained this cycle
    assign out_free = !r_out_valid || m_axis_tready;

    mrfb_payload_shift u_pay (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (pay_ctl),
        .i_bytes (pay_bytes),
        .i_len   (pay_len),
        .o_byte  (pay_byte),
        .o_empty (pay_empty)
    );

    mrfb_crc_serial u_crc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (crc_ctl),
        .o_crc   (crc_val),
        .o_busy  (crc_busy)
    );

    // sequencer: next state and control
    always_comb begin
        n_state         = r_state;
        s_axis_tready   = 1'b0;
        pay_ctl         = '0;
        crc_ctl         = '0;
        crc_ctl.byte_in = pay_byte;
        out_load        = 1'b0;
        out_byte        = pay_byte;
        out_last        = 1'b0;
        case (r_state)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    pay_ctl.load = 1'b1;
                    crc_ctl.init = 1'b1;
                    n_state      = ST_LOAD;
                end
            end
            ST_LOAD: begin
                // hand the byte out and start folding it into the CRC
                if (out_free) begin
                    out_load      = 1'b1;
                    crc_ctl.load  = 1'b1;
                    pay_ctl.shift = 1'b1;
                    n_state       = ST_CRUNCH;
                end
            end
            ST_CRUNCH: begin
                if (!crc_busy) begin
                    n_state = pay_empty ? ST_CRC_LO : ST_LOAD;
                end
            end
            ST_CRC_LO: begin
                out_byte = crc_val[7:0];
                if (out_free) begin
                    out_load = 1'b1;
                    n_state  = ST_CRC_HI;
                end
            end
            ST_CRC_HI: begin
                out_byte = crc_val[15:8];
                out_last = 1'b1;
                if (out_free) begin
                    out_load = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // output register: hold until taken
    always_comb begin
        n_out_valid = r_out_valid;
        n_out_byte  = r_out_byte;
        n_out_last  = r_out_last;
        if (out_load) begin
            n_out_valid = 1'b1;
            n_out_byte  = out_byte;
            n_out_last  = out_last;
        end else if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_byte <= n_out_byte;
        r_out_last <= n_out_last;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_byte;
    assign m_axis_tlast  = r_out_last;

`ifndef SYNTH
    a_crc_busy_in_crunch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        crc_busy |-> (r_state == ST_CRUNCH))
        else $error("CRC unit running outside the crunch state");

    a_accept_presets_crc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> ((r_state == ST_LOAD) && (crc_val == CRC_INIT) && !pay_empty))
        else $error("accepted request did not preset CRC and payload");

    a_last_ends_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && out_last) |=> ((r_state == ST_IDLE) && pay_empty))
        else $error("final CRC byte issued without ending the frame");
`endif

endmodule

// ===== tb/sv/mrfb_frame_checker.sv =====
// Frame checker for the Modbus RTU frame builder: predicts each frame and compares its bytes.
module mrfb_frame_checker
    import mrfb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [87:0] i_s_tdata,
    input  logic [0:0]  i_s_tuser,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [7:0]  i_m_tdata,
    input  logic        i_m_tlast,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] value;
        logic       last;
    } t_frame_byte;

    t_frame_byte due_bytes[$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    // one byte of the reflected CRC-16, LSB first
    function automatic logic [15:0] crc16_fold(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] r;
        r = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        end
        return r;
    endfunction

    // expand one request into the bytes of its frame, CRC included
    function automatic void queue_frame(input logic cmd, input logic [87:0] req);
        logic [7:0]  payload[7];
        int          plen;
        logic [15:0] crc;
        payload[0] = req[7:0];
        payload[1] = req[15:8];
        if (cmd == CMD_REQUEST) begin
            payload[2] = req[31:24];
            payload[3] = req[23:16];
            payload[4] = req[47:40];
            payload[5] = req[39:32];
            payload[6] = 8'h00;
            plen       = 6;
        end else begin
            payload[2] = req[55:48];
            payload[3] = req[87:80];
            payload[4] = req[79:72];
            payload[5] = req[71:64];
            payload[6] = req[63:56];
            plen       = 7;
        end
        crc = CRC_INIT;
        for (int i = 0; i < plen; i++) begin
            crc = crc16_fold(crc, payload[i]);
            due_bytes.push_back('{value: payload[i], last: 1'b0});
        end
        due_bytes.push_back('{value: crc[7:0], last: 1'b0});
        due_bytes.push_back('{value: crc[15:8], last: 1'b1});
    endfunction

    always @(posedge i_clk) begin
        t_frame_byte want;
        if (i_rst_n) begin
            if (i_s_tvalid && i_s_tready)
                queue_frame(i_s_tuser[0], i_s_tdata);
            if (i_m_tvalid && i_m_tready) begin
                if (due_bytes.size() == 0) begin
                    $error("frame_byte %h arrived with no frame byte due", i_m_tdata);
                    o_fail_count = o_fail_count + 1;
                end else begin
                    want = due_bytes.pop_front();
                    if (i_m_tdata !== want.value) begin
                        $error("frame_byte mismatch: expected %h, actual %h",
                               want.value, i_m_tdata);
                        o_fail_count = o_fail_count + 1;
                    end
                    if (i_m_tlast !== want.last) begin
                        $error("last_byte mismatch: expected %b, actual %b",
                               want.last, i_m_tlast);
                        o_fail_count = o_fail_count + 1;
                    end
                end
            end
        end
        o_pending = due_bytes.size();
    end

endmodule

// ===== tb/sv/tb_top.sv =====
// Testbench top for the Modbus RTU frame builder: stimulus, back-pressure and verdict.
module tb_top
    import mrfb_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_ITEMS  = 250;
    localparam int CALM_ITEMS    = 40;   // closing stretch with no idling
    localparam int DRAIN_CYCLES  = 120;  // longer than one response frame

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [87:0] s_tdata = '0;
    logic [0:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;

    int fail_count;
    int pending;
    int cycle_count = 0;
    bit calm = 1'b1;     // no idling on either side while set
    bit running = 1'b0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    modbus_rtu_frame_builder_top dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tuser  (s_tuser),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata),
        .m_axis_tlast  (m_tlast)
    );

    mrfb_frame_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tlast    (m_tlast),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Bail out if the run hangs.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Lay the request fields out as the tdata port expects them.
    function automatic logic [87:0] pack_request(input logic [7:0] addr, input logic [7:0] func,
                                                 input logic [15:0] start, input logic [15:0] qty,
                                                 input logic [7:0] cnt, input logic [31:0] word);
        return {word, cnt, qty, start, func, addr};
    endfunction

    // Offer one request and hold it until the block takes it.
    task automatic send_request(input logic cmd, input logic [87:0] req);
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        s_tvalid   <= 1'b1;
        s_tdata    <= req;
        s_tuser[0] <= cmd;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    // Master side: stall in bursts while idling is allowed, else stay ready.
    initial begin
        @(posedge clk);
        while (!running) @(posedge clk);
        forever begin
            if (!calm && $urandom_range(0, 2) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge clk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
    end

    initial begin
        logic [95:0] noise;
        logic [87:0] req;
        logic        cmd;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        running = 1'b1;

        // Directed: field extremes, both frame kinds, ignored fields, back to back.
        send_request(CMD_REQUEST,  '0);
        send_request(CMD_REQUEST,  '1);
        send_request(CMD_RESPONSE, '0);
        send_request(CMD_RESPONSE, '1);
        // textbook read of ten holding registers from slave one
        send_request(CMD_REQUEST,  pack_request(8'h01, 8'h03, 16'h0000, 16'h000A, 8'h00, 32'h0));
        send_request(CMD_RESPONSE, pack_request(8'h01, 8'h03, 16'h0000, 16'h0000, 8'h04,
                                                32'h0001_0002));
        send_request(CMD_REQUEST,  pack_request(8'hAA, 8'h55, 16'hAA55, 16'h55AA, 8'hAA,
                                                32'h55AA_55AA));
        send_request(CMD_REQUEST,  pack_request(8'h55, 8'hAA, 16'h55AA, 16'hAA55, 8'h55,
                                                32'hAA55_AA55));
        send_request(CMD_RESPONSE, pack_request(8'hAA, 8'h55, 16'hAA55, 16'h55AA, 8'hAA,
                                                32'h55AA_55AA));
        send_request(CMD_RESPONSE, pack_request(8'h55, 8'hAA, 16'h55AA, 16'hAA55, 8'h55,
                                                32'hAA55_AA55));
        // ignored fields loaded with ones must leave the frame alone
        send_request(CMD_REQUEST,  pack_request(8'h00, 8'h00, 16'h0000, 16'h0000, 8'hFF,
                                                32'hFFFF_FFFF));
        send_request(CMD_RESPONSE, pack_request(8'h00, 8'h00, 16'hFFFF, 16'hFFFF, 8'h00,
                                                32'h0000_0000));
        send_request(CMD_REQUEST,  pack_request(8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 8'h00,
                                                32'h0));
        send_request(CMD_RESPONSE, pack_request(8'hFF, 8'hFF, 16'h0000, 16'h0000, 8'hFF,
                                                32'hFFFF_FFFF));
        send_request(CMD_REQUEST,  pack_request(8'h80, 8'h01, 16'h8000, 16'h0001, 8'h00,
                                                32'h0));
        send_request(CMD_RESPONSE, pack_request(8'h01, 8'h80, 16'h0000, 16'h0000, 8'h01,
                                                32'h8000_0001));

        // Random requests, idling on both sides, then a calm closing stretch.
        calm = 1'b0;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS - CALM_ITEMS)
                calm = 1'b1;
            noise = {$urandom, $urandom, $urandom};
            req   = noise[87:0];
            // push single fields to their extremes now and then
            case ($urandom_range(0, 7))
                0: req[7:0]   = ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00;
                1: req[15:8]  = ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00;
                2: req[31:16] = ($urandom_range(0, 1) == 1) ? 16'hFFFF : 16'h0000;
                3: req[47:32] = ($urandom_range(0, 1) == 1) ? 16'hFFFF : 16'h0000;
                4: req[87:56] = ($urandom_range(0, 1) == 1) ? 32'hFFFF_FFFF : 32'h0;
                default: ;
            endcase
            cmd = ($urandom_range(0, 1) == 1) ? CMD_RESPONSE : CMD_REQUEST;
            send_request(cmd, req);
        end
        s_tvalid <= 1'b0;

        // Drain, then give the block time to show any stray bytes.
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);

        if (pending != 0)
            $error("%0d frame bytes never arrived", pending);
        if (fail_count == 0 && pending == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
